// ===== rtl/sm4cbc_pkg.sv =====
package sm4cbc_pkg;

  localparam int unsigned RoundsDefault = 32;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_IV_HIGH  = 2'd2,
    CFG_IV_LOW   = 2'd3
  } cfg_idx_e;

  // Control of the shared round unit.
  typedef struct packed {
    logic        key_sched;  // 1: key schedule transform, 0: data transform
    logic [31:0] rk;         // CK word or round key
  } rnd_ctl_t;

  localparam logic [3:0][31:0] FK = '{32'hB27022DC, 32'h677D9197, 32'h56AA3350, 32'hA3B1BAC6};

  localparam logic [7:0] SBOX [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  localparam logic [31:0] CK [32] = '{
    32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269,
    32'h70777e85, 32'h8c939aa1, 32'ha8afb6bd, 32'hc4cbd2d9,
    32'he0e7eef5, 32'hfc030a11, 32'h181f262d, 32'h343b4249,
    32'h50575e65, 32'h6c737a81, 32'h888f969d, 32'ha4abb2b9,
    32'hc0c7ced5, 32'hdce3eaf1, 32'hf8ff060d, 32'h141b2229,
    32'h30373e45, 32'h4c535a61, 32'h686f767d, 32'h848b9299,
    32'ha0a7aeb5, 32'hbcc3cad1, 32'hd8dfe6ed, 32'hf4fb0209,
    32'h10171e25, 32'h2c333a41, 32'h484f565d, 32'h646b7279
  };

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // Byte-wise S-box substitution.
  function automatic logic [31:0] tau(input logic [31:0] v);
    tau = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [31:0] lin_data(input logic [31:0] b);
    lin_data = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic logic [31:0] lin_key(input logic [31:0] b);
    lin_key = b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

endpackage

// ===== rtl/sm4_cbc_block_encryptor_core.sv =====
// SM4-CBC block encryptor.
// Config: plain write port (cfg_we_i, cfg_idx_i, cfg_data_i): key high/low, IV high/low.
//   Writing either key half marks the round keys stale. Write only while idle.
// Input channel (in_valid_i/in_ready_o): one 128-bit plaintext block per item plus
//   chain_start_i, which chains from the IV instead of the previous ciphertext.
// Output channel (out_valid_o/out_ready_i): one 128-bit ciphertext per item, held in
//   an output register until taken.
// Timing: one shared SM4 round unit runs one round per cycle. With valid round keys
//   an item runs all rounds in the encrypt state, then the finish state loads the
//   output register; the next item is taken only once the sequencer is back in idle.
//   After a key write the first item first runs the key schedule on the same round
//   unit and then its rounds as above.
//   in_ready_o is high only while the sequencer is idle.
// Stall: a finished block waits in the finish state while the output register still
//   holds an untaken result; the sequencer and in_ready_o stay blocked meanwhile.
// Reset: config and chaining value clear to zero, round keys are marked stale,
//   output channel empty. Round key memory is not cleared (always filled before use).
module sm4_cbc_block_encryptor_core #(
  parameter int unsigned ROUNDS = sm4cbc_pkg::RoundsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        chain_start_i,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o
);

  localparam int unsigned AW = $clog2(ROUNDS);
  localparam logic [AW-1:0] LastRound = AW'(ROUNDS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYEXP,
    ST_ENC,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic [AW-1:0] round_q;
  logic keys_ready_q;
  logic out_valid_q;
  logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic [63:0] chain_high_q, chain_low_q;

  // payload, no reset
  logic [3:0][31:0] x_q;     // round state, x_q[0] is the oldest word
  logic [127:0] blk_q;       // whitened block parked during key schedule
  logic [63:0] cipher_high_q, cipher_low_q;

  logic accept, out_free, last_round;
  logic [63:0] cv_high, cv_low;
  logic [127:0] blk;
  logic [31:0] nw, rk_rdata;
  logic [AW-1:0] rk_raddr;
  sm4cbc_pkg::rnd_ctl_t rnd_ctl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_round = (round_q == LastRound);

  // CBC whitening
  assign cv_high = chain_start_i ? iv_high_q : chain_high_q;
  assign cv_low  = chain_start_i ? iv_low_q  : chain_low_q;
  assign blk     = {plain_high_i ^ cv_high, plain_low_i ^ cv_low};

  // Read one round ahead so rk[r] is on rdata during round r; idle reads rk[0].
  assign rk_raddr = (state_q == ST_ENC) ? round_q + AW'(1) : '0;

  always_comb begin
    rnd_ctl.key_sched = (state_q == ST_KEYEXP);
    rnd_ctl.rk        = rnd_ctl.key_sched ? sm4cbc_pkg::CK[round_q] : rk_rdata;
  end

  sm4cbc_round u_round (
    .x_i   (x_q),
    .ctl_i (rnd_ctl),
    .nw_o  (nw)
  );

  sm4cbc_rk_mem #(
    .DEPTH (ROUNDS),
    .AW    (AW)
  ) u_rk_mem (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_KEYEXP),
    .waddr_i (round_q),
    .wdata_i (nw),
    .raddr_i (rk_raddr),
    .rdata_o (rk_rdata)
  );

  // Sequencer, config and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      round_q      <= '0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
      key_high_q   <= '0;
      key_low_q    <= '0;
      iv_high_q    <= '0;
      iv_low_q     <= '0;
      chain_high_q <= '0;
      chain_low_q  <= '0;
    end else begin
      // a new result refills the output register in the cycle the old one leaves
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sm4cbc_pkg::CFG_KEY_HIGH: begin
            key_high_q   <= cfg_data_i;
            keys_ready_q <= 1'b0;
          end
          sm4cbc_pkg::CFG_KEY_LOW: begin
            key_low_q    <= cfg_data_i;
            keys_ready_q <= 1'b0;
          end
          sm4cbc_pkg::CFG_IV_HIGH: iv_high_q <= cfg_data_i;
          sm4cbc_pkg::CFG_IV_LOW:  iv_low_q  <= cfg_data_i;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            round_q <= '0;
            if (chain_start_i) begin
              chain_high_q <= iv_high_q;
              chain_low_q  <= iv_low_q;
            end
            state_q <= keys_ready_q ? ST_ENC : ST_KEYEXP;
          end
        end
        ST_KEYEXP: begin
          round_q <= round_q + AW'(1);
          if (last_round) begin
            keys_ready_q <= 1'b1;
            state_q      <= ST_ENC;
          end
        end
        ST_ENC: begin
          round_q <= round_q + AW'(1);
          if (last_round) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            chain_high_q <= {x_q[3], x_q[2]};
            chain_low_q  <= {x_q[1], x_q[0]};
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Round state and output data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      blk_q <= blk;
      if (keys_ready_q) begin
        x_q <= {blk[31:0], blk[63:32], blk[95:64], blk[127:96]};
      end else begin
        x_q <= {key_low_q[31:0] ^ sm4cbc_pkg::FK[3], key_low_q[63:32] ^ sm4cbc_pkg::FK[2],
                key_high_q[31:0] ^ sm4cbc_pkg::FK[1], key_high_q[63:32] ^ sm4cbc_pkg::FK[0]};
      end
    end else if (state_q == ST_KEYEXP && last_round) begin
      x_q <= {blk_q[31:0], blk_q[63:32], blk_q[95:64], blk_q[127:96]};
    end else if (state_q == ST_KEYEXP || state_q == ST_ENC) begin
      x_q <= {nw, x_q[3], x_q[2], x_q[1]};
    end
    if (state_q == ST_FINISH && out_free) begin
      // reversed word order on output
      cipher_high_q <= {x_q[3], x_q[2]};
      cipher_low_q  <= {x_q[1], x_q[0]};
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_high_o = cipher_high_q;
  assign cipher_low_o  = cipher_low_q;

endmodule

// ===== rtl/sm4cbc_round.sv =====
// One SM4 round, shared by the key schedule and the data path.
module sm4cbc_round (
  input  logic [3:0][31:0]    x_i,
  input  sm4cbc_pkg::rnd_ctl_t ctl_i,
  output logic [31:0]         nw_o
);

  logic [31:0] sub;

  always_comb begin
    sub = sm4cbc_pkg::tau(x_i[1] ^ x_i[2] ^ x_i[3] ^ ctl_i.rk);
    if (ctl_i.key_sched) begin
      nw_o = x_i[0] ^ sm4cbc_pkg::lin_key(sub);
    end else begin
      nw_o = x_i[0] ^ sm4cbc_pkg::lin_data(sub);
    end
  end

endmodule

// ===== rtl/sm4cbc_rk_mem.sv =====
// Round key store: one write port, one registered read port.
module sm4cbc_rk_mem #(
  parameter int unsigned DEPTH = sm4cbc_pkg::RoundsDefault,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sm4cbc_checker.sv =====
module sm4cbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] cipher_high_o,
  input logic [63:0] cipher_low_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cipher_high_o)
                                    && $stable(cipher_low_o))
    else $error("output item changed while stalled");

  // block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // no result appears in the cycle after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // a new result only comes out of a busy period
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without work");

endmodule

bind sm4_cbc_block_encryptor_core sm4cbc_checker u_sm4cbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .cipher_high_o (cipher_high_o),
  .cipher_low_o  (cipher_low_o)
);
